// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the utf-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodePointW = 32;
  localparam int unsigned CountW     = 3;
  localparam int unsigned FollowBits = 6;

  // lead byte classification
  typedef struct packed {
    logic [CountW-1:0]     followers;
    logic [FollowBits-1:0] data_mask;
  } utf8d_lead_t;

  // result handed from the accumulator to the output register
  typedef struct packed {
    logic                  emit;
    logic [CodePointW-1:0] code_point;
    logic                  cut_short;
    logic                  last;
  } utf8d_result_t;

endpackage

// ===== hw/rtl/utf8_to_codepoint_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_core
// Decodes utf-8 bytes into code points, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_byte_i, string_end_i
//  out     | output    | out_valid_o/out_ready_i| code_point_o, cut_short_o,
//          |           |                        | last_of_string_o
//
// one byte per cycle while the output is not stalled; a byte is registered
// on accept and decoded into the output register once that register is free
// or draining, so each result passes the byte stage, then the output register.
// reset clears the pending sequence and both valid flags.
// a stalled output holds the byte stage, and with that stage full the
// input stalls too, whether or not the waiting byte finishes a code point.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_core
  import utf8d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ByteW-1:0]      in_byte_i,
  input  logic                  string_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CodePointW-1:0] code_point_o,
  output logic                  cut_short_o,
  output logic                  last_of_string_o
);

  logic                  in_valid_q;
  logic [ByteW-1:0]      byte_q;
  logic                  last_q;
  logic                  out_valid_q, out_valid_d;
  logic [CodePointW-1:0] code_point_q;
  logic                  cut_short_q;
  logic                  last_out_q;
  logic                  advance;
  logic                  in_fire;
  utf8d_result_t         result;

  // byte stage moves on when the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_byte_i;
      last_q <= string_end_i;
    end
  end

  utf8d_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_q),
    .last_i    (last_q),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = result.emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.emit) begin
      code_point_q <= result.code_point;
      cut_short_q  <= result.cut_short;
      last_out_q   <= result.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_point_o     = code_point_q;
  assign cut_short_o      = cut_short_q;
  assign last_of_string_o = last_out_q;

endmodule

// ===== hw/rtl/utf8d_lead_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_lead_decode
// Counts the ones below the top bit of a lead byte and builds its data mask.
// ----------------------------------------------------------------------------
module utf8d_lead_decode
  import utf8d_pkg::*;
(
  input  logic [ByteW-1:0] lead_byte_i,
  output utf8d_lead_t      lead_o
);

  logic [CountW-1:0] count;

  // leading-ones count over bits 6 down to 1, saturating at six
  always_comb begin
    if (!lead_byte_i[6]) begin
      count = CountW'(0);
    end else if (!lead_byte_i[5]) begin
      count = CountW'(1);
    end else if (!lead_byte_i[4]) begin
      count = CountW'(2);
    end else if (!lead_byte_i[3]) begin
      count = CountW'(3);
    end else if (!lead_byte_i[2]) begin
      count = CountW'(4);
    end else if (!lead_byte_i[1]) begin
      count = CountW'(5);
    end else begin
      count = CountW'(6);
    end
  end

  assign lead_o.followers = count;
  assign lead_o.data_mask = {FollowBits{1'b1}} >> count;

endmodule

// ===== hw/rtl/utf8d_accum.sv =====
// ----------------------------------------------------------------------------
// utf8d_accum
// Holds the partial value and pending byte count; folds in one byte per
// transaction and flags when a code point is complete or the string ends.
// ----------------------------------------------------------------------------
module utf8d_accum
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output utf8d_result_t    result_o
);

  logic [CodePointW-1:0] partial_q, partial_d;
  logic [CountW-1:0]     expected_q, expected_d;
  logic [CodePointW-1:0] value;
  logic [CountW-1:0]     remaining;
  logic                  emit;
  utf8d_lead_t           lead;

  utf8d_lead_decode u_lead_decode (
    .lead_byte_i (byte_i),
    .lead_o      (lead)
  );

  always_comb begin
    if (expected_q == CountW'(0)) begin
      if (!byte_i[ByteW-1]) begin
        value     = {{(CodePointW-ByteW+1){1'b0}}, byte_i[ByteW-2:0]};
        remaining = CountW'(0);
      end else begin
        value     = {{(CodePointW-FollowBits){1'b0}},
                     byte_i[FollowBits-1:0] & lead.data_mask};
        remaining = lead.followers;
      end
    end else begin
      // upper bits fall off the top
      value     = {partial_q[CodePointW-FollowBits-1:0], byte_i[FollowBits-1:0]};
      remaining = expected_q - CountW'(1);
    end
  end

  assign emit = (remaining == CountW'(0)) || last_i;

  always_comb begin
    partial_d  = partial_q;
    expected_d = expected_q;
    if (advance_i) begin
      if (emit) begin
        partial_d  = '0;
        expected_d = '0;
      end else begin
        partial_d  = value;
        expected_d = remaining;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q  <= '0;
      expected_q <= '0;
    end else begin
      partial_q  <= partial_d;
      expected_q <= expected_d;
    end
  end

  assign result_o.emit       = emit;
  assign result_o.code_point = value;
  assign result_o.cut_short  = (remaining != CountW'(0));
  assign result_o.last       = last_i;

endmodule

// ===== hw/rtl/utf8d_checker.sv =====
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [CodePointW-1:0] code_point_o,
  input logic                  cut_short_o,
  input logic                  last_of_string_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o)
      && $stable(cut_short_o) && $stable(last_of_string_o))
    else $error("result changed while stalled");

  // a truncated sequence only shows at the end of a string
  a_cut_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cut_short_o |-> last_of_string_o)
    else $error("cut_short without end of string");

  // an unfinished sequence holds at most thirty bits
  a_cut_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cut_short_o |-> code_point_o[CodePointW-1 -: 2] == 2'b00)
    else $error("truncated value too wide");

  // input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind utf8_to_codepoint_decoder_core utf8d_checker u_utf8d_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .code_point_o     (code_point_o),
  .cut_short_o      (cut_short_o),
  .last_of_string_o (last_of_string_o)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the utf-8 to code point decoder. Byte strings go in
// over the input channel and each byte is decoded by an in-bench predictor
// when it is accepted. Every code point that comes out is compared against the
// oldest predicted one. Stimulus is directed corner bytes, a long output
// hold-off, and random strings under several idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CodePointW-1:0] code_point;
    logic                  cut_short;
    logic                  last;
  } char_result_t;

  typedef logic [ByteW-1:0] byte_q_t[$];

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [ByteW-1:0]      in_byte_i    = '0;
  logic                  string_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [CodePointW-1:0] code_point_o;
  logic                  cut_short_o;
  logic                  last_of_string_o;

  // predictor state
  logic [CodePointW-1:0] acc_value   = '0;
  logic [CountW-1:0]     acc_pending = '0;

  char_result_t due_code_points[$];
  int           err_count     = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           holdoff_left  = 0;

  utf8_to_codepoint_decoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .string_end_i     (string_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_point_o     (code_point_o),
    .cut_short_o      (cut_short_o),
    .last_of_string_o (last_of_string_o)
  );

  always #2 clk_i = ~clk_i;

  // appends one byte to the tail of a string
  function automatic void queue_byte(ref byte_q_t s, input logic [ByteW-1:0] b);
    s.insert(s.size(), b);
  endfunction

  // returns 1 when the byte completes a code point or ends the string
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic last,
                                     output char_result_t res);
    int n;
    n   = 0;
    res = '0;
    if (acc_pending == '0) begin
      if (!b[7]) begin
        acc_value = {{(CodePointW-7){1'b0}}, b[6:0]};
      end else begin
        // leading ones below the top bit, saturating at six
        while (n < 6 && b[6-n]) n++;
        acc_value   = b & ((32'd1 << (6 - n)) - 1);
        acc_pending = CountW'(n);
      end
    end else begin
      acc_value   = {acc_value[CodePointW-7:0], b[5:0]};
      acc_pending = acc_pending - 1'b1;
    end
    if (acc_pending != '0 && !last) return 1'b0;
    res.code_point = acc_value;
    res.cut_short  = (acc_pending != '0);
    res.last       = last;
    acc_value      = '0;
    acc_pending    = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [CodePointW-1:0] want,
                                 input logic [CodePointW-1:0] got);
    if (err_count < 100) begin
      $display("tb: mismatch %s at %0t: expected %h, got %h", what, $realtime, want, got);
    end
    err_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    char_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= ByteW'($urandom_range(255));
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    string_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_byte(b, last, res)) due_code_points.insert(due_code_points.size(), res);
    @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (due_code_points.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_idle_pct = 6;
    recv_idle_pct = 77;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // stray continuation bytes arriving as leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // string ends right on a multi-byte lead
    send_byte(8'hF0, 1'b1);
    // string ends one byte into a three-byte sequence
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b1);
    // all-ones lead, all-ones followers: upper bits fall off the top
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    repeat (6) send_byte(8'h80, 1'b0);
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    holdoff_left = 80;
    @(negedge clk_i);
    for (int i = 0; i < 40; i++) begin
      send_byte(i[0] ? ByteW'(8'h80 | $urandom_range(63)) : ByteW'($urandom_range(127)),
                i == 39);
    end
  endtask

  task automatic test_random_strings(input int snd_pct, input int rcv_pct, input int n_bytes);
    byte_q_t    s;
    int         sent;
    int         kind;
    int         n;
    int         cut;
    logic [7:0] lead;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent          = 0;
    while (sent < n_bytes) begin
      s    = {};
      kind = $urandom_range(99);
      if (kind < 88) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(9))
            0, 1, 2, 3: queue_byte(s, ByteW'($urandom_range(127)));
            4:          queue_byte(s, ByteW'(8'h80 | $urandom_range(63)));
            default: begin
              n    = ($urandom_range(3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
              lead = 8'(~(8'hFF >> (n + 1)) | ($urandom_range(255) & ((8'd1 << (6 - n)) - 1)));
              if (n == 6 && $urandom_range(1)) lead[0] = 1'b1;
              queue_byte(s, lead);
              // followers are not checked, so some carry arbitrary top bits
              repeat (n) begin
                queue_byte(s, ($urandom_range(9) == 0) ? ByteW'($urandom_range(255))
                                                       : ByteW'(8'h80 | $urandom_range(63)));
              end
            end
          endcase
        end
        // broken strings stop at a random point
        if (kind >= 76 && s.size() > 1) begin
          cut = $urandom_range(1, s.size() - 1);
          s   = s[0:cut-1];
        end
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(s, ByteW'($urandom_range(255)));
        foreach (s[i]) send_byte(s[i], $urandom_range(3) == 0);
      end
      sent += s.size();
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_ready_i <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    char_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_code_points.size() == 0) begin
        report_mismatch("unexpected result", '0, code_point_o);
      end else begin
        want = due_code_points.pop_front();
        if (code_point_o !== want.code_point) begin
          report_mismatch("code_point", want.code_point, code_point_o);
        end
        if (cut_short_o !== want.cut_short) begin
          report_mismatch("cut_short", CodePointW'(want.cut_short),
                          CodePointW'(cut_short_o));
        end
        if (last_of_string_o !== want.last) begin
          report_mismatch("last_of_string", CodePointW'(want.last),
                          CodePointW'(last_of_string_o));
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    wait_all_results();
    test_output_holdoff();
    wait_all_results();
    test_random_strings(6, 77, 600);
    wait_all_results();
    test_random_strings(77, 6, 600);
    wait_all_results();
    test_random_strings(0, 0, 600);
    wait_all_results();
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_lead_decode.sv
hw/rtl/utf8d_accum.sv
hw/rtl/utf8_to_codepoint_decoder_core.sv
hw/rtl/utf8d_checker.sv
dv/tb.sv
